### hw/rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared widths, constants and register indexes for the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

   localparam int WORD_W  = 32;
   localparam int ROUND_W = 8;
   localparam int CSR_IDX_W = 3;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [ROUND_W-1:0] round_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // round constant added to the running sum once per round, subtracted on decrypt
   localparam word_type TEA_DELTA = 32'h9E37_79B9;

   // reset round count
   localparam round_type ROUND_RESET = 8'd32;

   // configuration register indexes
   localparam csr_idx_type CSR_KEY0   = 3'd0;
   localparam csr_idx_type CSR_KEY1   = 3'd1;
   localparam csr_idx_type CSR_KEY2   = 3'd2;
   localparam csr_idx_type CSR_KEY3   = 3'd3;
   localparam csr_idx_type CSR_ROUNDS = 3'd4;

   // operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // operands of one half-round on the shared mix unit
   typedef struct packed {
      word_type v;
      word_type sum;
      word_type kl;
      word_type kr;
      word_type acc;
      logic     subtract;
   } mix_op_type;

endpackage

### hw/rtl/tea_stream_if.sv
// ----------------------------------------------------------------------------
// tea_req_if / tea_rsp_if
// Valid/ready channels carrying request and response beats of the cipher.
// ----------------------------------------------------------------------------
interface tea_req_if
   import tea_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     req_type;
   word_type block_left;
   word_type block_right;

   modport source (output valid, output req_type, output block_left,
                   output block_right, input ready);
   modport sink   (input valid, input req_type, input block_left,
                   input block_right, output ready);
endinterface

interface tea_rsp_if
   import tea_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type out_left;
   word_type out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

### hw/rtl/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt of one 64-bit block per request beat.
// One half-round per cycle on the single shared mix unit, two passes per round.
// A new request is accepted only in idle, after the previous block has finished.
// A response waiting in the output register does not block the next request.
// Reset: synchronous, active high; keys clear to zero, round count to 32.
// ----------------------------------------------------------------------------
module tea_block_cipher
   import tea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tea_req_if.sink     req_bus,
   tea_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  csr_idx_type csr_index,
   input  word_type    csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0] state_ff,  state_in;
   word_type   key0_ff, key1_ff, key2_ff, key3_ff;
   round_type  rounds_ff;
   word_type   y_ff, y_in;
   word_type   z_ff, z_in;
   word_type   sum_ff, sum_in;
   round_type  cnt_ff, cnt_in;
   logic       phase_ff, phase_in;
   logic       decrypt_ff, decrypt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_left_ff, rsp_left_in;
   word_type   rsp_right_ff, rsp_right_in;

   mix_op_type mix_op;
   word_type   mix_result;
   word_type   dec_sum;
   logic       out_free;
   logic       req_beat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff   <= '0;
         key1_ff   <= '0;
         key2_ff   <= '0;
         key3_ff   <= '0;
         rounds_ff <= ROUND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY0:   key0_ff   <= csr_wdata;
            CSR_KEY1:   key1_ff   <= csr_wdata;
            CSR_KEY2:   key2_ff   <= csr_wdata;
            CSR_KEY3:   key3_ff   <= csr_wdata;
            CSR_ROUNDS: rounds_ff <= csr_wdata[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   // starting sum for decryption: delta times round count, mod 2^32
   assign dec_sum = TEA_DELTA * {{(WORD_W-ROUND_W){1'b0}}, rounds_ff};

   // operand select for the shared unit
   // phase 0 updates y on encrypt / z on decrypt, phase 1 the other half
   always_comb begin
      mix_op.sum      = sum_ff;
      mix_op.subtract = decrypt_ff;
      if (phase_ff == decrypt_ff) begin
         // y gets a term built from z
         mix_op.v   = z_ff;
         mix_op.kl  = key0_ff;
         mix_op.kr  = key1_ff;
         mix_op.acc = y_ff;
      end else begin
         // z gets a term built from y
         mix_op.v   = y_ff;
         mix_op.kl  = key2_ff;
         mix_op.kr  = key3_ff;
         mix_op.acc = z_ff;
      end
   end

   tea_mix u_mix (
      .op     (mix_op),
      .result (mix_result)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      decrypt_in   = decrypt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               y_in       = req_bus.block_left;
               z_in       = req_bus.block_right;
               decrypt_in = req_bus.req_type;
               sum_in     = (req_bus.req_type == OP_DECRYPT) ? dec_sum : TEA_DELTA;
               cnt_in     = rounds_ff;
               phase_in   = 1'b0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_left_in  = y_ff;
                  rsp_right_in = z_ff;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_WAIT;
               end
            end else begin
               if (phase_ff == decrypt_ff) begin
                  y_in = mix_result;
               end else begin
                  z_in = mix_result;
               end
               phase_in = !phase_ff;
               // a round ends after its second half
               if (phase_ff) begin
                  sum_in = decrypt_ff ? (sum_ff - TEA_DELTA) : (sum_ff + TEA_DELTA);
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = y_ff;
               rsp_right_in = z_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      z_ff         <= z_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      phase_ff     <= phase_in;
      decrypt_ff   <= decrypt_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   // response beat
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_left  = rsp_left_ff;
   assign rsp_bus.out_right = rsp_right_ff;

endmodule

### hw/rtl/tea_mix.sv
// ----------------------------------------------------------------------------
// tea_mix
// Shared half-round unit: builds the TEA mix term of one half and adds it
// to or subtracts it from the other half.
// ----------------------------------------------------------------------------
module tea_mix
   import tea_pkg::*;
(
   input  mix_op_type op,
   output word_type   result
);

   word_type term;

   // ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr)
   assign term = ((op.v << 4) + op.kl) ^ (op.v + op.sum) ^ ((op.v >> 5) + op.kr);

   // fold into the other half
   assign result = op.subtract ? (op.acc - term) : (op.acc + term);

endmodule

### dv/tea_block_cipher_test.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_test
// Self-checking bench for the TEA cipher. Key words and round count are
// changed only while no block is in flight. A short list of directed vectors
// covers zero keys, all-ones keys, zero, one, 32 and 255 rounds, and writes to
// spare register indexes. Randomized phases follow, each with a fresh key and
// round count. Every response beat is compared, in request order, with a local
// TEA model or a known result; both channels stall at random but in the last third.
// ----------------------------------------------------------------------------
module tea_block_cipher_test;
   import tea_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BLOCKS = 1150;
   localparam int QUIET_LIMIT   = 5000;

   // register indexes past the key and round registers, writes are dropped
   localparam csr_idx_type CSR_SPARE_FIRST = 3'd5;
   localparam csr_idx_type CSR_SPARE_LAST  = 3'd7;

   typedef struct packed {
      word_type left;
      word_type right;
   } block_type;

   typedef struct packed {
      logic        is_write;
      csr_idx_type idx;
      word_type    wdata;
      logic        op;
      word_type    left;
      word_type    right;
      logic        known;
      word_type    want_left;
      word_type    want_right;
   } vector_row_type;

   logic clock;
   logic reset;
   logic        csr_we;
   csr_idx_type csr_index;
   word_type    csr_wdata;

   tea_req_if req_bus ();
   tea_rsp_if rsp_bus ();

   tea_block_cipher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // copy of the cipher's configuration
   word_type  key_mirror [4];
   round_type rounds_mirror;

   // blocks still owed by the cipher, oldest first
   block_type awaited_blocks [$];
   block_type staged_block;
   block_type last_block;

   vector_row_type directed_rows [$];

   int fail_count     = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 15;
   int recv_stall_pct = 55;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one tea half-round term
   function automatic word_type tea_mix(word_type v, word_type sum, word_type kl,
                                        word_type kr);
      return ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr);
   endfunction

   // full block transform under the mirrored key and round count
   function automatic block_type tea_transform(logic op, word_type left, word_type right);
      word_type y;
      word_type z;
      word_type sum;
      y = left;
      z = right;
      if (op == OP_ENCRYPT) begin
         sum = '0;
         for (int r = 0; r < rounds_mirror; r++) begin
            sum = sum + TEA_DELTA;
            y = y + tea_mix(z, sum, key_mirror[0], key_mirror[1]);
            z = z + tea_mix(y, sum, key_mirror[2], key_mirror[3]);
         end
      end else begin
         sum = TEA_DELTA * word_type'(rounds_mirror);
         for (int r = 0; r < rounds_mirror; r++) begin
            z = z - tea_mix(y, sum, key_mirror[2], key_mirror[3]);
            y = y - tea_mix(z, sum, key_mirror[0], key_mirror[1]);
            sum = sum - TEA_DELTA;
         end
      end
      return {y, z};
   endfunction

   function automatic vector_row_type csr_row(csr_idx_type idx, word_type data);
      vector_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.idx = idx;
      row.wdata = data;
      return row;
   endfunction

   function automatic vector_row_type item_row(logic op, word_type left, word_type right);
      vector_row_type row;
      row = '0;
      row.op = op;
      row.left = left;
      row.right = right;
      return row;
   endfunction

   function automatic vector_row_type known_row(logic op, word_type left, word_type right,
                                                word_type want_left, word_type want_right);
      vector_row_type row;
      row = item_row(op, left, right);
      row.known = 1'b1;
      row.want_left = want_left;
      row.want_right = want_right;
      return row;
   endfunction

   // random word biased toward the extremes
   function automatic word_type pick_word();
      int roll;
      roll = $urandom_range(15, 0);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return 32'h8000_0000;
      return $urandom;
   endfunction

   // register write, mirror follows
   task automatic write_csr(csr_idx_type idx, word_type data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_KEY0:   key_mirror[0] = data;
         CSR_KEY1:   key_mirror[1] = data;
         CSR_KEY2:   key_mirror[2] = data;
         CSR_KEY3:   key_mirror[3] = data;
         CSR_ROUNDS: rounds_mirror = data[ROUND_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // hold off requests until every owed block is back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one request beat, with random idle cycles ahead of it
   task automatic send_block(logic op, word_type left, word_type right, logic known,
                             word_type want_left, word_type want_right);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      staged_block = known ? {want_left, want_right} : tea_transform(op, left, right);
      last_block = staged_block;
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= op;
      req_bus.block_left  <= left;
      req_bus.block_right <= right;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // response side stalls
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // scoreboard and watchdog
   always @(posedge clock) begin
      block_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_blocks.size() == 0) begin
               $error("result beat with nothing owed: left %h right %h",
                      rsp_bus.out_left, rsp_bus.out_right);
               fail_count++;
            end else begin
               want = awaited_blocks.pop_front();
               if (rsp_bus.out_left !== want.left) begin
                  $error("out_left: expected %h, got %h", want.left, rsp_bus.out_left);
                  fail_count++;
               end
               if (rsp_bus.out_right !== want.right) begin
                  $error("out_right: expected %h, got %h", want.right, rsp_bus.out_right);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) awaited_blocks.push_back(staged_block);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tea_block_cipher_test: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // stimulus
   initial begin
      int          random_sent;
      int          phase_blocks;
      int          roll;
      round_type   rounds;
      logic        op;
      vector_row_type row;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = OP_ENCRYPT;
      req_bus.block_left = '0;
      req_bus.block_right = '0;
      foreach (key_mirror[i]) key_mirror[i] = '0;
      rounds_mirror = ROUND_RESET;
      staged_block = '0;
      last_block = '0;

      // reset state: zero key, 32 rounds
      directed_rows.push_back(item_row(OP_ENCRYPT, '0, '0));
      directed_rows.push_back(item_row(OP_DECRYPT, '0, '0));
      directed_rows.push_back(item_row(OP_ENCRYPT, '1, '1));
      directed_rows.push_back(item_row(OP_DECRYPT, '1, '1));
      // mixed key words
      directed_rows.push_back(csr_row(CSR_KEY0, 32'h1234_5678));
      directed_rows.push_back(csr_row(CSR_KEY1, 32'h5678_9ABC));
      directed_rows.push_back(csr_row(CSR_KEY2, 32'hABCD_ABCD));
      directed_rows.push_back(csr_row(CSR_KEY3, 32'h37A9_EFC3));
      directed_rows.push_back(item_row(OP_ENCRYPT, 32'h1234_5678, 32'h5678_9ABC));
      directed_rows.push_back(item_row(OP_DECRYPT, 32'h8C03_2341, 32'h7076_9C64));
      // zero rounds pass the block through
      directed_rows.push_back(csr_row(CSR_ROUNDS, 32'h0000_0000));
      directed_rows.push_back(known_row(OP_ENCRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                        32'hA5A5_A5A5, 32'h5A5A_5A5A));
      directed_rows.push_back(known_row(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0000));
      // one round, upper bits of the round write dropped
      directed_rows.push_back(csr_row(CSR_ROUNDS, 32'hFFFF_FF01));
      directed_rows.push_back(item_row(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001));
      directed_rows.push_back(item_row(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000));
      // spare index must leave the keys alone
      directed_rows.push_back(csr_row(CSR_SPARE_FIRST, '1));
      directed_rows.push_back(csr_row(CSR_SPARE_LAST, '1));
      directed_rows.push_back(item_row(OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D));
      // most rounds, all-ones key
      directed_rows.push_back(csr_row(CSR_ROUNDS, 32'h0000_00FF));
      directed_rows.push_back(csr_row(CSR_KEY0, '1));
      directed_rows.push_back(csr_row(CSR_KEY1, '1));
      directed_rows.push_back(csr_row(CSR_KEY2, '1));
      directed_rows.push_back(csr_row(CSR_KEY3, '1));
      directed_rows.push_back(item_row(OP_ENCRYPT, '1, '1));
      directed_rows.push_back(item_row(OP_DECRYPT, '0, '0));

      // reset held over rising edges, then released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed vectors
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_write) begin
            wait_drained();
            write_csr(row.idx, row.wdata);
         end else begin
            send_block(row.op, row.left, row.right, row.known, row.want_left,
                       row.want_right);
         end
      end

      // random phases, fresh configuration each
      random_sent = 0;
      while (random_sent < RANDOM_BLOCKS) begin
         if (random_sent < RANDOM_BLOCKS / 3) begin
            send_idle_pct = 15;
            recv_stall_pct = 55;
         end else if (random_sent < 2 * RANDOM_BLOCKS / 3) begin
            send_idle_pct = 55;
            recv_stall_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end

         wait_drained();
         write_csr(CSR_KEY0, pick_word());
         write_csr(CSR_KEY1, pick_word());
         write_csr(CSR_KEY2, pick_word());
         write_csr(CSR_KEY3, pick_word());
         roll = $urandom_range(19, 0);
         if (roll == 0) rounds = '0;
         else if (roll == 1) rounds = '1;
         else if (roll == 2) rounds = round_type'($urandom_range(254, 128));
         else if (roll == 3) rounds = 8'd1;
         else rounds = round_type'($urandom_range(40, 2));
         write_csr(CSR_ROUNDS, {24'($urandom_range(32'h00FF_FFFF, 0)), rounds});
         if ($urandom_range(3, 0) == 0)
            write_csr(csr_idx_type'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)),
                      $urandom);

         // long round counts get short phases
         phase_blocks = (rounds >= 128) ? $urandom_range(8, 3) : $urandom_range(60, 20);
         repeat (phase_blocks) begin
            op = 1'($urandom_range(1, 0));
            if ($urandom_range(3, 0) == 0) begin
               // undo or redo the previous block
               send_block(op, last_block.left, last_block.right, 1'b0, '0, '0);
            end else begin
               send_block(op, pick_word(), pick_word(), 1'b0, '0, '0);
            end
            random_sent++;
         end
      end

      // drain and report
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && awaited_blocks.size() == 0) begin
         $display("tea_block_cipher_test: done, clean");
      end else begin
         $display("tea_block_cipher_test: done, errors");
      end
      $finish;
   end

endmodule
